>>> rtl/pmsg_pkg.sv
package pmsg_pkg;

  typedef logic [3:0] shape_t;
  typedef logic [3:0] stroke_idx_t;
  typedef logic [3:0] scale_t;
  typedef logic [4:0] code_t;
  typedef logic signed [13:0] value_t;

  typedef struct packed {
    logic              kind;
    logic signed [4:0] mx;
    logic signed [4:0] my;
  } stroke_t;

  localparam logic STROKE_MOVE = 1'b0;
  localparam logic STROKE_DRAW = 1'b1;

  localparam shape_t SHAPE_BOX      = 4'd0;
  localparam shape_t SHAPE_CIRCLE   = 4'd1;
  localparam shape_t SHAPE_UP_TRI   = 4'd2;
  localparam shape_t SHAPE_PLUS     = 4'd3;
  localparam shape_t SHAPE_CROSS    = 4'd4;
  localparam shape_t SHAPE_DIAMOND  = 4'd5;
  localparam shape_t SHAPE_DOWN_TRI = 4'd6;
  localparam shape_t SHAPE_HOURGLASS = 4'd7;
  localparam shape_t SHAPE_STAR     = 4'd8;

  localparam int SHAPE_COUNT   = 9;
  localparam int ALT_CODE_BASE = 10;
  localparam int VAL_MAX       = 8191;
  localparam int VAL_MIN       = -8192;
  localparam scale_t SCALE_RESET = 4'd2;

  function automatic stroke_t mk(logic kind, int x, int y);
    stroke_t s;
    s.kind = kind;
    s.mx   = 5'(x);
    s.my   = 5'(y);
    return s;
  endfunction

  function automatic stroke_idx_t shape_len(shape_t s);
    stroke_idx_t n;
    case (s)
      SHAPE_BOX:       n = 4'd5;
      SHAPE_CIRCLE:    n = 4'd9;
      SHAPE_UP_TRI:    n = 4'd4;
      SHAPE_PLUS:      n = 4'd4;
      SHAPE_CROSS:     n = 4'd4;
      SHAPE_DIAMOND:   n = 4'd5;
      SHAPE_DOWN_TRI:  n = 4'd4;
      SHAPE_HOURGLASS: n = 4'd5;
      SHAPE_STAR:      n = 4'd8;
      default:         n = 4'd1;
    endcase
    return n;
  endfunction

  // Stroke table: kind and offsets in units of the marker scale.
  function automatic stroke_t stroke_at(shape_t s, stroke_idx_t k);
    stroke_t r;
    r = mk(STROKE_MOVE, 0, 0);
    case (s)
      SHAPE_BOX: begin
        case (k)
          4'd0: r = mk(STROKE_MOVE, -3, 3);
          4'd1: r = mk(STROKE_DRAW, 6, 0);
          4'd2: r = mk(STROKE_DRAW, 0, -6);
          4'd3: r = mk(STROKE_DRAW, -6, 0);
          4'd4: r = mk(STROKE_DRAW, 0, 6);
          default: r = mk(STROKE_MOVE, 0, 0);
        endcase
      end
      SHAPE_CIRCLE: begin
        case (k)
          4'd0: r = mk(STROKE_MOVE, -3, -1);
          4'd1: r = mk(STROKE_DRAW, 0, 2);
          4'd2: r = mk(STROKE_DRAW, 2, 2);
          4'd3: r = mk(STROKE_DRAW, 2, 0);
          4'd4: r = mk(STROKE_DRAW, 2, -2);
          4'd5: r = mk(STROKE_DRAW, 0, -2);
          4'd6: r = mk(STROKE_DRAW, -2, -2);
          4'd7: r = mk(STROKE_DRAW, -2, 0);
          4'd8: r = mk(STROKE_DRAW, -2, 2);
          default: r = mk(STROKE_MOVE, 0, 0);
        endcase
      end
      SHAPE_UP_TRI: begin
        case (k)
          4'd0: r = mk(STROKE_MOVE, -4, -2);
          4'd1: r = mk(STROKE_DRAW, 4, 6);
          4'd2: r = mk(STROKE_DRAW, 4, -6);
          4'd3: r = mk(STROKE_DRAW, -8, 0);
          default: r = mk(STROKE_MOVE, 0, 0);
        endcase
      end
      SHAPE_PLUS: begin
        case (k)
          4'd0: r = mk(STROKE_MOVE, 0, 2);
          4'd1: r = mk(STROKE_DRAW, 0, -4);
          4'd2: r = mk(STROKE_MOVE, -3, 0);
          4'd3: r = mk(STROKE_DRAW, 6, 0);
          default: r = mk(STROKE_MOVE, 0, 0);
        endcase
      end
      SHAPE_CROSS: begin
        case (k)
          4'd0: r = mk(STROKE_MOVE, -3, -3);
          4'd1: r = mk(STROKE_DRAW, 6, 6);
          4'd2: r = mk(STROKE_MOVE, -3, 3);
          4'd3: r = mk(STROKE_DRAW, 6, -6);
          default: r = mk(STROKE_MOVE, 0, 0);
        endcase
      end
      SHAPE_DIAMOND: begin
        case (k)
          4'd0: r = mk(STROKE_MOVE, 0, 4);
          4'd1: r = mk(STROKE_DRAW, 4, -4);
          4'd2: r = mk(STROKE_DRAW, -4, -4);
          4'd3: r = mk(STROKE_DRAW, -4, 4);
          4'd4: r = mk(STROKE_DRAW, 4, 4);
          default: r = mk(STROKE_MOVE, 0, 0);
        endcase
      end
      SHAPE_DOWN_TRI: begin
        case (k)
          4'd0: r = mk(STROKE_MOVE, -4, 2);
          4'd1: r = mk(STROKE_DRAW, 8, 0);
          4'd2: r = mk(STROKE_DRAW, -4, -6);
          4'd3: r = mk(STROKE_DRAW, -4, 6);
          default: r = mk(STROKE_MOVE, 0, 0);
        endcase
      end
      SHAPE_HOURGLASS: begin
        case (k)
          4'd0: r = mk(STROKE_MOVE, -3, -3);
          4'd1: r = mk(STROKE_DRAW, 6, 6);
          4'd2: r = mk(STROKE_DRAW, -6, 0);
          4'd3: r = mk(STROKE_DRAW, 6, -6);
          4'd4: r = mk(STROKE_DRAW, -6, 0);
          default: r = mk(STROKE_MOVE, 0, 0);
        endcase
      end
      SHAPE_STAR: begin
        case (k)
          4'd0: r = mk(STROKE_MOVE, -4, 0);
          4'd1: r = mk(STROKE_DRAW, 8, 0);
          4'd2: r = mk(STROKE_MOVE, -3, 3);
          4'd3: r = mk(STROKE_DRAW, 6, -6);
          4'd4: r = mk(STROKE_MOVE, 0, 4);
          4'd5: r = mk(STROKE_DRAW, 0, -8);
          4'd6: r = mk(STROKE_MOVE, -3, -3);
          4'd7: r = mk(STROKE_DRAW, 6, 6);
          default: r = mk(STROKE_MOVE, 0, 0);
        endcase
      end
      default: r = mk(STROKE_MOVE, 0, 0);
    endcase
    return r;
  endfunction

endpackage

>>> rtl/pmsg_if.sv
interface pmsg_in_if #(
  parameter int COORD_BITS = 12
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] x_pos;
  logic [COORD_BITS-1:0] y_pos;
  logic [4:0]            marker_code;

  modport source (output valid, output x_pos, output y_pos, output marker_code, input ready);
  modport sink   (input valid, input x_pos, input y_pos, input marker_code, output ready);
endinterface

interface pmsg_out_if ();
  logic               valid;
  logic               ready;
  logic               stroke_kind;
  logic signed [13:0] x_value;
  logic signed [13:0] y_value;
  logic               last;

  modport source (output valid, output stroke_kind, output x_value, output y_value,
                  output last, input ready);
  modport sink   (input valid, input stroke_kind, input x_value, input y_value,
                  input last, output ready);
endinterface

>>> rtl/pmsg_front.sv
module pmsg_front #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pmsg_in_if.sink               in_ch,
  output logic                  q_valid,
  input  logic                  q_pop,
  output logic [COORD_BITS-1:0] q_x,
  output logic [COORD_BITS-1:0] q_y,
  output pmsg_pkg::shape_t      q_shape
);
  import pmsg_pkg::*;

  // Two-entry queue between classification and stroke sequencing.
  logic [COORD_BITS-1:0] x_r [2];
  logic [COORD_BITS-1:0] y_r [2];
  shape_t                shape_r [2];
  logic                  wr_ptr_r, rd_ptr_r;
  logic [1:0]            count_r;

  code_t  shape_raw;
  logic   draws;
  logic   push;
  logic   pop;

  always_comb begin
    shape_raw = (in_ch.marker_code >= 5'(ALT_CODE_BASE))
                ? in_ch.marker_code - 5'(ALT_CODE_BASE) : in_ch.marker_code;
    draws     = (shape_raw < 5'(SHAPE_COUNT));
    // Codes without a shape are accepted and dropped here.
    push      = in_ch.valid && in_ch.ready && draws;
    pop       = q_pop && (count_r != 2'd0);
  end

  assign in_ch.ready = (count_r != 2'd2);
  assign q_valid     = (count_r != 2'd0);
  assign q_x         = x_r[rd_ptr_r];
  assign q_y         = y_r[rd_ptr_r];
  assign q_shape     = shape_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      x_r[wr_ptr_r]     <= in_ch.x_pos;
      y_r[wr_ptr_r]     <= in_ch.y_pos;
      shape_r[wr_ptr_r] <= shape_raw[3:0];
    end
  end

endmodule

>>> rtl/pmsg_back.sv
module pmsg_back #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pmsg_pkg::scale_t      scale,
  input  logic                  q_valid,
  output logic                  q_pop,
  input  logic [COORD_BITS-1:0] q_x,
  input  logic [COORD_BITS-1:0] q_y,
  input  pmsg_pkg::shape_t      q_shape,
  pmsg_out_if.source            out_ch
);
  import pmsg_pkg::*;

  // Wide enough for the centre plus an offset and for the saturation limits.
  localparam int SW = (COORD_BITS + 2 > 15) ? COORD_BITS + 2 : 15;
  localparam logic signed [SW-1:0] SAT_HI = SW'(VAL_MAX);
  localparam logic signed [SW-1:0] SAT_LO = SW'(VAL_MIN);

  stroke_idx_t k_r;
  logic        out_valid_r;
  logic        kind_r, last_r;
  value_t      xv_r, yv_r;

  stroke_t            st;
  stroke_idx_t        len;
  logic               is_last;
  logic               advance;
  logic signed [8:0]  unit_w, mx_w, my_w, dx, dy;
  logic signed [SW-1:0] sum_x, sum_y;
  value_t             xv, yv;

  always_comb begin
    advance = !out_valid_r || out_ch.ready;
    st      = stroke_at(q_shape, k_r);
    len     = shape_len(q_shape);
    is_last = (k_r == len - 4'd1);
    q_pop   = advance && q_valid && is_last;

    unit_w = {5'b0, scale};
    mx_w   = {{4{st.mx[4]}}, st.mx};
    my_w   = {{4{st.my[4]}}, st.my};
    dx     = mx_w * unit_w;
    dy     = my_w * unit_w;

    sum_x = $signed({{(SW-COORD_BITS){1'b0}}, q_x}) + {{(SW-9){dx[8]}}, dx};
    sum_y = $signed({{(SW-COORD_BITS){1'b0}}, q_y}) + {{(SW-9){dy[8]}}, dy};

    if (st.kind == STROKE_DRAW) begin
      xv = {{5{dx[8]}}, dx};
      yv = {{5{dy[8]}}, dy};
    end else begin
      if (sum_x > SAT_HI)      xv = SAT_HI[13:0];
      else if (sum_x < SAT_LO) xv = SAT_LO[13:0];
      else                     xv = sum_x[13:0];
      if (sum_y > SAT_HI)      yv = SAT_HI[13:0];
      else if (sum_y < SAT_LO) yv = SAT_LO[13:0];
      else                     yv = sum_y[13:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      k_r         <= 4'd0;
    end else if (advance) begin
      out_valid_r <= q_valid;
      if (q_valid) k_r <= is_last ? 4'd0 : k_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && q_valid) begin
      kind_r <= st.kind;
      xv_r   <= xv;
      yv_r   <= yv;
      last_r <= is_last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.stroke_kind = kind_r;
  assign out_ch.x_value     = xv_r;
  assign out_ch.y_value     = yv_r;
  assign out_ch.last        = last_r;

endmodule

>>> rtl/plot_marker_stroke_generator_unit.sv
// Channel | Direction | Payload                                   | Handshake
// in_ch   | input     | x_pos, y_pos (COORD_BITS), marker_code (5) | valid/ready
// out_ch  | output    | stroke_kind, x_value, y_value (14 s), last | valid/ready
// cfg     | input     | cfg_wdata = marker_scale (4)               | cfg_we
//
// A marker has four to nine strokes, and the stroke sequencer reads one table
// entry and emits one stroke per cycle while the output is not stalled.
// Codes without a shape are accepted and produce nothing.
// Reset sets marker_scale to 2 and empties the two-entry queue and output stage.
// A stalled output holds its stroke; the front keeps accepting items until
// the queue is full, so input and output stall independently.
module plot_marker_stroke_generator_unit #(
  parameter int COORD_BITS = 12
) (
  input  logic         clk,
  input  logic         rst_n,
  pmsg_in_if.sink      in_ch,
  pmsg_out_if.source   out_ch,
  input  logic         cfg_we,
  input  logic [3:0]   cfg_wdata
);
  import pmsg_pkg::*;

  // The marker scale register. The user must see that it is written only while
  // the block is idle, so the sequencer may read it directly; the block does not enforce it.
  scale_t scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
    end else if (cfg_we) begin
      scale_r <= cfg_wdata;
    end
  end

  // Queue head, shared between the front and the back.
  logic                  q_valid;
  logic                  q_pop;
  logic [COORD_BITS-1:0] q_x;
  logic [COORD_BITS-1:0] q_y;
  shape_t                q_shape;

  // The front classifies the code, folds the alternate codes onto the basic
  // shapes and queues only items that draw something.
  pmsg_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_x     (q_x),
    .q_y     (q_y),
    .q_shape (q_shape)
  );

  // The back walks the stroke table of the head item, scales the offsets,
  // turns moves into saturated absolute points and pops the item with its
  // last stroke, so the next marker follows without a gap.
  pmsg_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .scale   (scale_r),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_x     (q_x),
    .q_y     (q_y),
    .q_shape (q_shape),
    .out_ch  (out_ch)
  );

endmodule
